/* rtl/core/pls_pkg.sv */
// Shared types and constants for the positional list store.
// Used by pls_ctrl, pls_dp and positional_list_store; depends on nothing.
`default_nettype none

package pls_pkg;

  // Defaults for the top-level parameters.
  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths of the request and the result.
  localparam int OPCODE_W = 3;
  localparam int POS_W    = 5;
  localparam int ENTRY_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int LIMIT_W  = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_GET     = 3'd2,
    OP_REPLACE = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic {
    ST_EMPTY = 1'b0,
    ST_FULL  = 1'b1
  } state_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic exec;
  } pls_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/positional_list_store.sv */
// Top level of the positional list store: stream ports, configuration port.
// Depends on pls_pkg, pls_ctrl and pls_dp.
//
// An ordered list of up to CAPACITY entries addressed by 1-based position.
// Each request item on the slave stream carries an opcode (insert, remove,
// get, replace, clear), a position and an entry, and produces exactly one
// result item on the master stream with ok, the read value and the count
// after the request. Insert shifts every later entry up one cell and remove
// shifts them down one cell, all cells moving in the same clock, so every
// request finishes in the cycle it is accepted and its result is shown from
// the next cycle in an output register. A new request is accepted in the
// cycle the previous result is taken, so the block sustains one item per
// cycle when the downstream side keeps tready high. A request that cannot
// be performed (position 0 or out of range, insert into a full list, an
// unused opcode) leaves the list untouched and reports ok = 0 with a read
// value of zero. The capacity limit register is written through the cfg
// channel, which is always ready; it should be written only while no
// request is outstanding. A limit above CAPACITY acts as CAPACITY and a
// limit of zero makes every insert fail. Entries are kept to DATA_WIDTH bits
// (at most 32); cells at unused positions are never read.
`default_nettype none

module positional_list_store
  import pls_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Request stream.
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [39:0]        s_tdata,   // opcode[2:0], position[7:3], entry[39:8]
  // Result stream.
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [39:0]             m_tdata,   // ok[0], read_value[32:1], count[37:33], zero
  // Capacity limit write channel.
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LIMIT_W-1:0] cfg_data
);

  pls_cmd_t             cmd;
  logic                 res_ok;
  logic [ENTRY_W-1:0]   res_rd;
  logic [COUNT_W-1:0]   res_count;

  assign cfg_ready = 1'b1;

  pls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  pls_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .opcode    (s_tdata[2:0]),
    .position  (s_tdata[7:3]),
    .entry     (s_tdata[39:8]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .res_ok    (res_ok),
    .res_rd    (res_rd),
    .res_count (res_count)
  );

  assign m_tdata = {2'b00, res_count, res_rd, res_ok};

endmodule

`default_nettype wire

/* rtl/core/pls_ctrl.sv */
// Handshake controller of the positional list store.
// Depends on pls_pkg; drives pls_dp through a pls_cmd_t command.
`default_nettype none

module pls_ctrl
  import pls_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  wire logic     m_tready,
  output pls_cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    case (state)
      ST_EMPTY: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_FULL;
        end
      end
      ST_FULL: begin
        // The result register is freed in the same cycle it is taken.
        m_tvalid = 1'b1;
        s_tready = m_tready;
        if (m_tready && !s_tvalid) begin
          state_next = ST_EMPTY;
        end
      end
      default: begin
        state_next = ST_EMPTY;
      end
    endcase
    cmd.exec = s_tvalid && s_tready;
  end

endmodule

`default_nettype wire

/* rtl/core/pls_dp.sv */
// Datapath of the positional list store: a row of entry cells that shift
// in parallel, the occupancy and limit registers and the result register.
// Depends on pls_pkg; commanded by pls_ctrl.
`default_nettype none

module pls_dp
  import pls_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pls_cmd_t            cmd,
  input  wire logic [OPCODE_W-1:0] opcode,
  input  wire logic [POS_W-1:0]    position,
  input  wire logic [ENTRY_W-1:0]  entry,
  input  wire logic                cfg_we,
  input  wire logic [LIMIT_W-1:0]  cfg_data,
  output logic                     res_ok,
  output logic [ENTRY_W-1:0]       res_rd,
  output logic [COUNT_W-1:0]       res_count
);

  localparam int SW   = (DATA_WIDTH < ENTRY_W) ? DATA_WIDTH : ENTRY_W;
  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [CMPW-1:0] CAP_C = CMPW'(CAPACITY);

  logic [SW-1:0]      cells      [CAPACITY];
  logic [SW-1:0]      cells_next [CAPACITY];
  logic [SW-1:0]      up_src     [CAPACITY];
  logic [SW-1:0]      dn_src     [CAPACITY];
  logic [CW-1:0]      occ;
  logic [CW-1:0]      occ_next;
  logic [LIMIT_W-1:0] limit;

  logic [POS_W-1:0] pos_m1;
  logic [IW-1:0]    idx;
  logic [SW-1:0]    val_s;
  logic [CMPW-1:0]  pos_c;
  logic [CMPW-1:0]  occ_c;
  logic [CMPW-1:0]  lim_c;
  logic [CMPW-1:0]  eff_c;
  logic             pos_in;
  logic             ok_c;
  logic [ENTRY_W-1:0] rd_c;

  // Neighbor taps for the shift up (insert) and shift down (remove).
  for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
    if (g == 0) begin : g_first
      assign up_src[g] = cells[g];
    end else begin : g_rest
      assign up_src[g] = cells[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign dn_src[g] = cells[g];
    end else begin : g_inner
      assign dn_src[g] = cells[g+1];
    end
  end

  always_comb begin
    pos_m1 = position - POS_W'(1);
    idx    = IW'(pos_m1);
    val_s  = SW'(entry);
    pos_c  = CMPW'(position);
    occ_c  = CMPW'(occ);
    lim_c  = CMPW'(limit);
    eff_c  = (lim_c > CAP_C) ? CAP_C : lim_c;
    pos_in = (pos_c != '0) && (pos_c <= occ_c);

    cells_next = cells;
    occ_next   = occ;
    ok_c       = 1'b0;
    rd_c       = '0;
    case (opcode)
      OP_INSERT: begin
        if ((pos_c != '0) && (pos_c <= occ_c + CMPW'(1)) && (occ_c < eff_c)) begin
          ok_c     = 1'b1;
          occ_next = occ + CW'(1);
          for (int i = 0; i < CAPACITY; i++) begin
            if (IW'(i) == idx) begin
              cells_next[i] = val_s;
            end else if (IW'(i) > idx) begin
              cells_next[i] = up_src[i];
            end
          end
        end
      end
      OP_REMOVE: begin
        if (pos_in) begin
          ok_c     = 1'b1;
          occ_next = occ - CW'(1);
          for (int i = 0; i < CAPACITY; i++) begin
            if (IW'(i) >= idx) begin
              cells_next[i] = dn_src[i];
            end
          end
        end
      end
      OP_GET: begin
        if (pos_in) begin
          ok_c = 1'b1;
          rd_c = ENTRY_W'(cells[idx]);
        end
      end
      OP_REPLACE: begin
        if (pos_in) begin
          ok_c            = 1'b1;
          rd_c            = ENTRY_W'(cells[idx]);
          cells_next[idx] = val_s;
        end
      end
      OP_CLEAR: begin
        ok_c     = 1'b1;
        occ_next = '0;
      end
      default: begin
        ok_c = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ   <= '0;
      limit <= LIMIT_RESET;
    end else begin
      if (cmd.exec) begin
        occ <= occ_next;
      end
      if (cfg_we) begin
        limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      cells     <= cells_next;
      res_ok    <= ok_c;
      res_rd    <= rd_c;
      res_count <= COUNT_W'(occ_next);
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    CMPW'(occ) <= CAP_C)
    else $error("occupancy above capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && (opcode == OP_CLEAR) |=> (occ == '0) && res_ok)
    else $error("clear did not empty the list");

  a_fail_reads_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> res_ok || (res_rd == '0))
    else $error("failed request returned a nonzero value");

  a_get_keeps_count: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && (opcode == OP_GET) |=> occ == $past(occ))
    else $error("get changed the occupancy");
`endif

endmodule

`default_nettype wire
